// File: design/rgbg_pkg.sv
`timescale 1ns / 1ps

package rgbg_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_GAIN = 2'd0;
  localparam logic [1:0] CFG_BPP  = 2'd1;

  localparam logic [15:0] GAIN_RESET = 16'd256;
  localparam logic [2:0]  BPP_RESET  = 3'd3;
  localparam logic [2:0]  BPP_MIN_CORRECT = 3'd3;

  // 255.0 in 8.8, widened to the product width
  localparam logic [23:0] FULL_8_8 = 24'd65280;

  localparam int unsigned NUM_LANES  = 3;
  localparam int unsigned QUOT_BITS  = 8;
  localparam int unsigned DIV_STEPS_PER_STAGE = 2;
  localparam int unsigned NUM_DIV_STAGES = QUOT_BITS / DIV_STEPS_PER_STAGE;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       end_of_image;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_out;
  } pix_out_t;

  // Word carried through the divider stages.
  // acc holds {remainder, dividend bits still to shift / quotient bits}.
  typedef struct packed {
    logic [NUM_LANES-1:0][15:0] acc;
    logic [7:0]                 divisor;
    logic [NUM_LANES-1:0][7:0]  fallback;
    logic                       use_div;
    logic                       last;
  } div_word_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [15:0] div_step(logic [15:0] acc, logic [7:0] divisor);
    logic [8:0] trial;
    logic [8:0] diff;
    trial = {acc[15:8], acc[7]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      return {diff[7:0], acc[6:0], 1'b1};
    end
    return {trial[7:0], acc[6:0], 1'b0};
  endfunction

endpackage

// File: design/rgb_gain_with_hue_preserving_clip.sv
`timescale 1ns / 1ps

// RGB gain with hue-preserving clip. Each pixel word carries red, green and
// blue bytes plus an end-of-image flag. Every channel is multiplied by the
// unsigned 8.8 gain register (256 = 1.0). If no product exceeds 255.0 the
// channels are the products with the fraction dropped; if any product
// exceeds it, all three are rescaled so the largest channel lands on exactly
// 255 and the channel ratios are kept (results truncated). A bytes_per_pixel
// value below 3 passes the pixel through unchanged. Throughput is one pixel
// per clock unless out_ready_i back-pressure stalls the pipe. The pipe holds
// two front stages (multiply, then clip decision), four restoring-divider
// stages at two quotient bits each, and the output register. Write the
// registers only while no pixel is in flight. Register 0 is gain, register
// 1 is bytes_per_pixel; other indexes are ignored.
module rgb_gain_with_hue_preserving_clip (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rgbg_pkg::pix_in_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rgbg_pkg::pix_out_t out_word_o
);
  import rgbg_pkg::*;

  // Configuration registers
  logic [15:0] gain_q;
  logic [2:0]  bpp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      bpp_q  <= BPP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN: gain_q <= cfg_wdata_i;
        CFG_BPP:  bpp_q  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  // Divider chain: index 0 is the front output, the last index feeds the output register
  logic                  chain_valid [NUM_DIV_STAGES+1];
  logic                  chain_ready [NUM_DIV_STAGES+1];
  div_word_t             chain_word  [NUM_DIV_STAGES+1];

  rgbg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gain_i       (gain_q),
    .correct_en_i (bpp_q >= BPP_MIN_CORRECT),
    .valid_i      (in_valid_i),
    .ready_o      (in_ready_o),
    .word_i       (in_word_i),
    .valid_o      (chain_valid[0]),
    .ready_i      (chain_ready[0]),
    .word_o       (chain_word[0])
  );

  for (genvar k = 0; k < NUM_DIV_STAGES; k++) begin : g_div
    rgbg_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .word_i  (chain_word[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .word_o  (chain_word[k+1])
    );
  end

  // Output register: pick quotient or the fallback byte per channel
  logic     out_valid_q;
  pix_out_t out_word_q, out_word_d;
  div_word_t tail;

  assign tail = chain_word[NUM_DIV_STAGES];

  always_comb begin
    out_word_d.red_out   = tail.use_div ? tail.acc[2][7:0] : tail.fallback[2];
    out_word_d.green_out = tail.use_div ? tail.acc[1][7:0] : tail.fallback[1];
    out_word_d.blue_out  = tail.use_div ? tail.acc[0][7:0] : tail.fallback[0];
    out_word_d.last_out  = tail.last;
  end

  // Advance when the output slot is empty or being drained
  assign chain_ready[NUM_DIV_STAGES] = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_ready[NUM_DIV_STAGES]) begin
      out_valid_q <= chain_valid[NUM_DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_valid[NUM_DIV_STAGES] && chain_ready[NUM_DIV_STAGES]) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Input only stalls when the whole pipe backs up behind a held output word
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // A clipped pixel always has one channel at full scale
  a_clip_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_valid[NUM_DIV_STAGES] && tail.use_div |->
      out_word_d.red_out == 8'hFF || out_word_d.green_out == 8'hFF ||
      out_word_d.blue_out == 8'hFF)
    else $error("clipped pixel without a full-scale channel");

endmodule

// File: design/rgbg_front.sv
`timescale 1ns / 1ps

module rgbg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         gain_i,
  input  logic                correct_en_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  rgbg_pkg::pix_in_t   word_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rgbg_pkg::div_word_t word_o
);
  import rgbg_pkg::*;

  // Stage A: products and largest channel
  logic                       a_valid_q;
  logic                       a_ready;
  logic [NUM_LANES-1:0][23:0] a_prod_q, a_prod_d;
  logic [NUM_LANES-1:0][7:0]  a_raw_q, a_raw_d;
  logic [7:0]                 a_cmax_q, a_cmax_d;
  logic                       a_bypass_q;
  logic                       a_last_q;

  // Stage B: clip decision and dividend setup
  logic      b_valid_q;
  div_word_t b_word_q, b_word_d;

  always_comb begin
    a_raw_d = {word_i.red_in, word_i.green_in, word_i.blue_in};
    for (int i = 0; i < NUM_LANES; i++) begin
      a_prod_d[i] = 24'(a_raw_d[i]) * 24'(gain_i);
    end
    a_cmax_d = a_raw_d[0];
    if (a_raw_d[1] > a_cmax_d) begin
      a_cmax_d = a_raw_d[1];
    end
    if (a_raw_d[2] > a_cmax_d) begin
      a_cmax_d = a_raw_d[2];
    end
  end

  assign ready_o = !a_valid_q || a_ready;
  assign a_ready = !b_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (ready_o) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      a_prod_q   <= a_prod_d;
      a_raw_q    <= a_raw_d;
      a_cmax_q   <= a_cmax_d;
      a_bypass_q <= !correct_en_i;
      a_last_q   <= word_i.end_of_image;
    end
  end

  // Gain cancels in p / pmax, so the rescale is c * 255 / cmax.
  always_comb begin
    logic clip;
    clip = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      clip = clip | (a_prod_q[i] > FULL_8_8);
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      b_word_d.acc[i]      = {a_raw_q[i], 8'h00} - {8'h00, a_raw_q[i]};
      b_word_d.fallback[i] = a_bypass_q ? a_raw_q[i] : a_prod_q[i][15:8];
    end
    b_word_d.divisor = a_cmax_q;
    b_word_d.use_div = !a_bypass_q && clip;
    b_word_d.last    = a_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && a_ready) begin
      b_word_q <= b_word_d;
    end
  end

  assign valid_o = b_valid_q;
  assign word_o  = b_word_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_word_q.use_div |-> b_word_q.divisor != 8'd0)
    else $error("clip word with zero divisor");

  a_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !ready_i |=> b_valid_q && $stable(b_word_q))
    else $error("stage B word changed while stalled");

endmodule

// File: design/rgbg_div.sv
`timescale 1ns / 1ps

module rgbg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  rgbg_pkg::div_word_t word_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rgbg_pkg::div_word_t word_o
);
  import rgbg_pkg::*;

  logic      valid_q;
  div_word_t word_q, word_d;

  always_comb begin
    word_d = word_i;
    for (int i = 0; i < NUM_LANES; i++) begin
      for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
        word_d.acc[i] = div_step(word_d.acc[i], word_i.divisor);
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

  // Remainder stays below the divisor on every lane of a clip word
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && word_q.use_div |->
      (word_q.acc[0][15:8] < word_q.divisor) &&
      (word_q.acc[1][15:8] < word_q.divisor) &&
      (word_q.acc[2][15:8] < word_q.divisor))
    else $error("divider remainder out of range");

endmodule

// File: bench/rgb_gain_with_hue_preserving_clip_tb.sv
`timescale 1ns / 1ps

module rgb_gain_with_hue_preserving_clip_tb;
  import rgbg_pkg::*;

  // Register indexes that the block must ignore
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  localparam logic [31:0] FULL_BYTE = 32'd255;
  // Pipeline is seven stages deep; give it some slack before touching registers
  localparam int PIPE_SETTLE = 12;
  localparam int RANDOM_PHASES = 14;
  localparam int WORDS_PER_PHASE = 102;
  localparam int TIMEOUT_NS = 2_000_000;

  // Expected-pixel store plus a private copy of both registers.
  class pixel_score;
    logic [15:0] gain_q;
    logic [2:0]  bpp_q;
    pix_out_t    expected_pixels[$];
    int          mismatches;

    function new();
      gain_q = GAIN_RESET;
      bpp_q = BPP_RESET;
      mismatches = 0;
    endfunction

    // Mirror a register write; indexes past the last register change nothing.
    function void apply_write(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_GAIN: begin
          gain_q = data;
        end
        CFG_BPP: begin
          bpp_q = data[2:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Multiply by the 8.8 gain; when any product passes 255.0, rescale all
    // three so the brightest lands on 255 and the ratios hold.
    function pix_out_t gain_clip_pixel(pix_in_t p);
      pix_out_t    q;
      logic [7:0]  chan[3];
      logic [23:0] prod[3];
      logic [23:0] peak;
      logic [31:0] scaled;
      int          i;
      chan[0] = p.red_in;
      chan[1] = p.green_in;
      chan[2] = p.blue_in;
      if (bpp_q >= BPP_MIN_CORRECT) begin
        for (i = 0; i < 3; i++) begin
          prod[i] = 24'(chan[i]) * 24'(gain_q);
        end
        peak = prod[0];
        if (prod[1] > peak) peak = prod[1];
        if (prod[2] > peak) peak = prod[2];
        for (i = 0; i < 3; i++) begin
          if (peak > FULL_8_8) begin
            scaled = (32'(prod[i]) * FULL_BYTE) / 32'(peak);
          end else begin
            scaled = 32'(prod[i] >> 8);
          end
          chan[i] = scaled[7:0];
        end
      end
      q.red_out = chan[0];
      q.green_out = chan[1];
      q.blue_out = chan[2];
      q.last_out = p.end_of_image;
      return q;
    endfunction

    function void note_pixel(pix_in_t p);
      expected_pixels.push_back(gain_clip_pixel(p));
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (expected_pixels.size() == 0) begin
        $error("result word with no pixel pending: %h", got);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red_out !== want.red_out) begin
        $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
        mismatches++;
      end
      if (got.green_out !== want.green_out) begin
        $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
        mismatches++;
      end
      if (got.blue_out !== want.blue_out) begin
        $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
        mismatches++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0d, got %0d", want.last_out, got.last_out);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  pix_in_t    in_word_i;
  logic       out_valid_o;
  logic       out_ready_i;
  pix_out_t   out_word_o;

  pixel_score sb = new();
  // When set, neither side inserts gaps: back-to-back words at full rate
  bit         burst_mode = 1'b0;

  rgb_gain_with_hue_preserving_clip dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int draw_gap();
    return burst_mode ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic pix_in_t px(int r, int g, int b, bit eoi);
    pix_in_t p;
    p.red_in = 8'(r);
    p.green_in = 8'(g);
    p.blue_in = 8'(b);
    p.end_of_image = eoi;
    return p;
  endfunction

  // Mix of plain random pixels, pixels parked right at the overflow knee of
  // the current gain, gray pixels and pixels with saturated/empty channels.
  function automatic pix_in_t random_pixel(logic [15:0] g);
    pix_in_t p;
    int      knee;
    int      lane;
    p.red_in = 8'($urandom);
    p.green_in = 8'($urandom);
    p.blue_in = 8'($urandom);
    p.end_of_image = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if (g != 16'd0) begin
          knee = int'(FULL_8_8) / int'(g) + $urandom_range(0, 1);
          if (knee > 255) knee = 255;
          p.red_in = 8'($urandom_range(0, knee));
          p.green_in = 8'($urandom_range(0, knee));
          p.blue_in = 8'($urandom_range(0, knee));
          lane = $urandom_range(0, 2);
          case (lane)
            0: p.red_in = 8'(knee);
            1: p.green_in = 8'(knee);
            default: p.blue_in = 8'(knee);
          endcase
        end
      end
      3: begin
        p.green_in = p.red_in;
        p.blue_in = p.red_in;
      end
      4: begin
        p.red_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue_in = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  // Offer one word; keep valid high into the next word when no gap is drawn.
  task automatic send_pixel(pix_in_t w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(w);
  endtask

  // Drop valid and hold until every expected word is back and the pipe is empty.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.apply_write(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: stall a random number of cycles, then take one word.
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_pixel(out_word_o);
    end
  end

  initial begin
    logic [15:0] gain_pick;
    logic [2:0]  bpp_pick;
    int          ph;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_GAIN;
    cfg_wdata_i <= 16'd0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gain of 1.0: words pass through the multiply untouched
    send_pixel(px(0, 0, 0, 0));
    send_pixel(px(255, 255, 255, 1));
    send_pixel(px(1, 128, 254, 0));
    drain_pipeline();

    // Largest gain: nearly everything clips, even a single unit
    write_reg(CFG_GAIN, 16'hFFFF);
    send_pixel(px(255, 255, 255, 0));
    send_pixel(px(255, 0, 1, 1));
    send_pixel(px(0, 0, 0, 0));
    send_pixel(px(1, 0, 0, 0));
    send_pixel(px(0, 0, 1, 1));
    drain_pipeline();

    // Zero gain blanks every channel
    write_reg(CFG_GAIN, 16'd0);
    send_pixel(px(255, 255, 255, 1));
    send_pixel(px(17, 200, 3, 0));
    drain_pipeline();

    // Just below and just above 1.0, around the overflow threshold
    write_reg(CFG_GAIN, 16'd255);
    send_pixel(px(255, 255, 255, 0));
    drain_pipeline();
    write_reg(CFG_GAIN, 16'd257);
    send_pixel(px(255, 254, 0, 1));
    send_pixel(px(254, 10, 0, 0));
    drain_pipeline();

    // Correction off for pixel sizes below three bytes
    write_reg(CFG_GAIN, 16'h0400);
    write_reg(CFG_BPP, 16'd2);
    send_pixel(px(255, 128, 7, 1));
    drain_pipeline();
    write_reg(CFG_BPP, 16'hFFF8);
    send_pixel(px(9, 8, 7, 0));
    drain_pipeline();
    write_reg(CFG_BPP, 16'd1);
    send_pixel(px(200, 100, 50, 1));
    drain_pipeline();

    // Writes to unused indexes must leave both registers alone
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h0000);
    send_pixel(px(3, 2, 1, 0));
    drain_pipeline();

    // Any size from three up enables correction
    write_reg(CFG_BPP, 16'd7);
    write_reg(CFG_GAIN, 16'h0180);
    send_pixel(px(255, 170, 0, 0));
    send_pixel(px(100, 50, 25, 1));
    drain_pipeline();
    write_reg(CFG_BPP, 16'd4);
    send_pixel(px(170, 171, 169, 0));
    drain_pipeline();

    // Random phases: new register values, then a stream of words
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 7))
        0: gain_pick = 16'd0;
        1: gain_pick = 16'hFFFF;
        2: gain_pick = GAIN_RESET;
        3: gain_pick = 16'($urandom_range(1, 255));
        4, 5: gain_pick = 16'($urandom_range(257, 1024));
        default: gain_pick = 16'($urandom);
      endcase
      if ($urandom_range(0, 9) < 3) begin
        bpp_pick = 3'($urandom_range(0, 2));
      end else begin
        bpp_pick = 3'($urandom_range(3, 7));
      end
      write_reg(CFG_GAIN, gain_pick);
      // Upper data bits are don't-care for the size register
      write_reg(CFG_BPP, {13'($urandom), bpp_pick});
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
      end
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat (WORDS_PER_PHASE) send_pixel(random_pixel(gain_pick));
      drain_pipeline();
    end

    burst_mode = 1'b0;
    drain_pipeline();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
